[rtl/core/ipq_pkg.sv]
// ipq_pkg: shared request and status codes, default sizes and the result record
// for the indexed max priority queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ipq_pkg;
	localparam int IPQ_CAPACITY  = 64;
	localparam int IPQ_KEY_WIDTH = 32;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_EXTRACT = 2'd1;
	localparam logic [1:0] REQ_CHANGE  = 2'd2;
	localparam logic [1:0] REQ_LOOKUP  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_DUP    = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         out_slot;
		logic signed [31:0] out_key;
		logic               present;
		logic [6:0]         occupancy;
	} ipq_res_t;
endpackage
`default_nettype wire

[rtl/core/ipq_ram.sv]
// ipq_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ipq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/ipq_engine.sv]
// ipq_engine: heap sequencer with one heap ram (slot and key per position) and
// one position map ram; depends on ipq_pkg and ipq_ram
`timescale 1ns / 1ps
`default_nettype none
module ipq_engine import ipq_pkg::*; #(
	parameter int CAPACITY  = IPQ_CAPACITY,
	parameter int KEY_WIDTH = IPQ_KEY_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  req,
	input  wire logic [5:0]  slot,
	input  wire logic [31:0] key,
	output logic             ready,
	output logic             done,
	output ipq_res_t         res
);
	localparam int SLW = $clog2(CAPACITY);
	localparam int PW  = $clog2(CAPACITY + 1);
	localparam int SW  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int EW  = SLW + SW;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PCHK  = 4'd2;
	localparam logic [3:0] S_XTOP  = 4'd3;
	localparam logic [3:0] S_XLAST = 4'd4;
	localparam logic [3:0] S_LKEY  = 4'd5;
	localparam logic [3:0] S_UISS  = 4'd6;
	localparam logic [3:0] S_UCMP  = 4'd7;
	localparam logic [3:0] S_DISS  = 4'd8;
	localparam logic [3:0] S_DL    = 4'd9;
	localparam logic [3:0] S_DR    = 4'd10;
	localparam logic [3:0] S_DCMP  = 4'd11;
	localparam logic [3:0] S_PLACE = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	function automatic logic signed [SW-1:0] ekey(input logic [EW-1:0] e);
		return $signed(e[SW-1:0]);
	endfunction

	function automatic logic [SLW-1:0] eslot(input logic [EW-1:0] e);
		return e[EW-1:SW];
	endfunction

	logic [3:0]           state_q;
	logic [PW-1:0]        cnt_q, k_q, j_q;
	logic [1:0]           req_q;
	logic [5:0]           slot_q, oslot_q;
	logic [SW-1:0]        key_q;
	logic signed [SW-1:0] okey_q;
	logic [EW-1:0]        e_q, c_q;
	logic                 moved_q, pres_q;
	logic [2:0]           status_q;
	logic [SLW-1:0]       clr_q;

	logic           h_we, p_we;
	logic [SLW-1:0] h_waddr, h_raddr, p_waddr, p_raddr;
	logic [EW-1:0]  h_wdata, h_rdata;
	logic [PW-1:0]  p_wdata, p_rdata;

	logic [PW:0]    lchild, rchild, cnt_x;
	logic [SLW-1:0] slot_idx;
	logic           slot_ok, go_down;

	assign lchild   = {k_q, 1'b0};
	assign rchild   = lchild + (PW+1)'(1);
	assign cnt_x    = {1'b0, cnt_q};
	assign slot_idx = SLW'(slot_q);
	assign slot_ok  = {26'd0, slot} < 32'(CAPACITY);
	assign go_down  = (req_q == REQ_CHANGE) && !moved_q;

	ipq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	ipq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	always_comb begin
		h_we    = 1'b0;
		h_waddr = SLW'(k_q - PW'(1));
		h_wdata = e_q;
		h_raddr = '0;
		p_we    = 1'b0;
		p_waddr = eslot(e_q);
		p_wdata = k_q;
		p_raddr = SLW'(slot);
		unique case (state_q)
			S_CLR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
			end
			S_XTOP: begin
				p_we    = 1'b1;
				p_waddr = eslot(h_rdata);
				p_wdata = '0;
				h_raddr = SLW'(cnt_q - PW'(1));
			end
			S_PCHK: h_raddr = SLW'(p_rdata - PW'(1));
			S_UISS: h_raddr = SLW'((k_q >> 1) - PW'(1));
			S_UCMP: begin
				if (ekey(e_q) > ekey(h_rdata)) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					p_we    = 1'b1;
					p_waddr = eslot(h_rdata);
				end
			end
			S_DISS: h_raddr = SLW'(lchild - (PW+1)'(1));
			S_DL:   h_raddr = SLW'(lchild);
			S_DCMP: begin
				if (ekey(c_q) > ekey(e_q)) begin
					h_we    = 1'b1;
					h_wdata = c_q;
					p_we    = 1'b1;
					p_waddr = eslot(c_q);
				end
			end
			S_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SLW'(1);
					if (clr_q == SLW'(CAPACITY - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						slot_q   <= slot;
						oslot_q  <= slot;
						key_q    <= key[SW-1:0];
						okey_q   <= '0;
						pres_q   <= 1'b0;
						moved_q  <= 1'b0;
						status_q <= ST_OK;
						if (req == REQ_EXTRACT) begin
							oslot_q <= '0;
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_XTOP;
							end
						end else if (!slot_ok) begin
							status_q <= ST_ABSENT;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_PCHK;
						end
					end
				end
				S_XTOP: begin
					oslot_q <= 6'(eslot(h_rdata));
					okey_q  <= ekey(h_rdata);
					cnt_q   <= cnt_q - PW'(1);
					state_q <= S_XLAST;
				end
				S_XLAST: begin
					e_q     <= h_rdata;
					k_q     <= PW'(1);
					state_q <= (cnt_q == '0) ? S_DONE : S_DISS;
				end
				S_PCHK: begin
					e_q <= {slot_idx, key_q};
					case (req_q)
						REQ_INSERT: begin
							pres_q <= p_rdata != '0;
							if (cnt_q == PW'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (p_rdata != '0) begin
								status_q <= ST_DUP;
								state_q  <= S_DONE;
							end else begin
								cnt_q   <= cnt_q + PW'(1);
								k_q     <= cnt_q + PW'(1);
								pres_q  <= 1'b1;
								state_q <= S_UISS;
							end
						end
						REQ_CHANGE: begin
							if (p_rdata == '0) begin
								status_q <= ST_ABSENT;
								state_q  <= S_DONE;
							end else begin
								k_q     <= p_rdata;
								pres_q  <= 1'b1;
								state_q <= S_UISS;
							end
						end
						default: begin
							if (p_rdata == '0) begin
								status_q <= ST_ABSENT;
								state_q  <= S_DONE;
							end else begin
								pres_q  <= 1'b1;
								state_q <= S_LKEY;
							end
						end
					endcase
				end
				S_LKEY: begin
					okey_q  <= ekey(h_rdata);
					state_q <= S_DONE;
				end
				S_UISS: begin
					if (k_q == PW'(1)) state_q <= go_down ? S_DISS : S_PLACE;
					else state_q <= S_UCMP;
				end
				S_UCMP: begin
					if (ekey(e_q) > ekey(h_rdata)) begin
						k_q     <= k_q >> 1;
						moved_q <= 1'b1;
						state_q <= S_UISS;
					end else begin
						state_q <= go_down ? S_DISS : S_PLACE;
					end
				end
				S_DISS: state_q <= (lchild > cnt_x) ? S_PLACE : S_DL;
				S_DL: begin
					c_q     <= h_rdata;
					j_q     <= PW'(lchild);
					state_q <= (rchild <= cnt_x) ? S_DR : S_DCMP;
				end
				S_DR: begin
					if (ekey(h_rdata) > ekey(c_q)) begin
						c_q <= h_rdata;
						j_q <= PW'(rchild);
					end
					state_q <= S_DCMP;
				end
				S_DCMP: begin
					if (ekey(c_q) > ekey(e_q)) begin
						k_q     <= j_q;
						state_q <= S_DISS;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready = state_q == S_IDLE;
	assign done  = state_q == S_DONE;

	always_comb begin
		res.status    = status_q;
		res.out_slot  = oslot_q;
		res.out_key   = 32'(okey_q);
		res.present   = pres_q;
		res.occupancy = 7'(cnt_q);
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PW'(CAPACITY))
		else $error("heap count above capacity");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("request started while busy");
	a_insert_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PCHK && req_q == REQ_INSERT && cnt_q != PW'(CAPACITY)
			&& p_rdata == '0) |=> cnt_q == $past(cnt_q) + PW'(1))
		else $error("insert did not grow the heap");
	a_extract_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_XTOP |=> cnt_q == $past(cnt_q) - PW'(1))
		else $error("extract did not shrink the heap");
endmodule
`default_nettype wire

[rtl/core/indexed_max_priority_queue.sv]
// Indexed binary max-heap over CAPACITY slots with signed keys. After reset the
// block clears its position map and holds in_stall high meanwhile. One
// request is served at a time by a sequencer sharing one heap ram and one position
// ram, each with one read and one write per cycle: lookup reads the position map
// and then the heap, insert and change climb the heap level by level (change
// then sifts down if it did not climb), and extract sifts down level by level.
// The result sits in an output register, so a
// new request is taken once the previous result beat has left or is leaving.
// depends on ipq_pkg and ipq_engine
`timescale 1ns / 1ps
`default_nettype none
module indexed_max_priority_queue import ipq_pkg::*; #(
	parameter int CAPACITY  = IPQ_CAPACITY,
	parameter int KEY_WIDTH = IPQ_KEY_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [5:0]         slot,
	input  wire logic signed [31:0] key,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [5:0]              out_slot,
	output logic signed [31:0]      out_key,
	output logic                    present,
	output logic [6:0]              occupancy
);
	logic     eng_ready, eng_done, start;
	ipq_res_t eng_res, res_q;
	logic     out_valid_q;

	assign in_stall = !eng_ready || (out_valid_q && out_stall);
	assign start    = in_valid && !in_stall;

	ipq_engine #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req_type),
		.slot(slot), .key(key), .ready(eng_ready), .done(eng_done), .res(eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			res_q <= eng_res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign out_slot  = res_q.out_slot;
	assign out_key   = res_q.out_key;
	assign present   = res_q.present;
	assign occupancy = res_q.occupancy;
endmodule
`default_nettype wire

[tb/indexed_max_priority_queue_tb.sv]
// indexed_max_priority_queue_tb: self-checking bench for the indexed max heap queue,
// with its own heap predictor, a queued driver, a stalling monitor and field checks
// depends on ipq_pkg and indexed_max_priority_queue
`timescale 1ns / 1ps
module indexed_max_priority_queue_tb;
	import ipq_pkg::*;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         slot;
		logic signed [31:0] key;
	} req_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_INSERT;
	logic [5:0] slot = '0;
	logic signed [31:0] key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [5:0] out_slot;
	logic signed [31:0] out_key;
	logic present;
	logic [6:0] occupancy;

	indexed_max_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .slot(slot), .key(key), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .out_slot(out_slot), .out_key(out_key),
		.present(present), .occupancy(occupancy)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted heap
	logic signed [31:0] slot_key [64];
	logic [5:0] heap_slot [1:64];
	logic [6:0] heap_pos [64];
	int heap_size;

	req_beat_t pending_reqs[$];
	ipq_res_t expected_results[$];
	int send_idle_pct = 23;
	int recv_idle_pct = 73;
	int errors = 0;
	int cycles = 0;
	bit stim_done = 1'b0;

	function automatic logic signed [31:0] key_of(int p);
		return slot_key[heap_slot[p]];
	endfunction

	function automatic void swap_entries(int a, int b);
		logic [5:0] t;
		t = heap_slot[a];
		heap_slot[a] = heap_slot[b];
		heap_slot[b] = t;
		heap_pos[heap_slot[a]] = a[6:0];
		heap_pos[heap_slot[b]] = b[6:0];
	endfunction

	function automatic int climb(int k);
		while (k > 1 && key_of(k) > key_of(k / 2)) begin
			swap_entries(k, k / 2);
			k = k / 2;
		end
		return k;
	endfunction

	function automatic void sink(int k);
		int j;
		while (2 * k <= heap_size) begin
			j = 2 * k;
			if (j + 1 <= heap_size && key_of(j + 1) > key_of(j))
				j++;
			if (key_of(j) <= key_of(k))
				break;
			swap_entries(j, k);
			k = j;
		end
	endfunction

	function automatic ipq_res_t serve_request(req_beat_t r);
		ipq_res_t res;
		logic [5:0] top;
		int p;
		res = '0;
		res.status = ST_OK;
		res.out_slot = r.slot;
		case (r.req_type)
			REQ_EXTRACT: begin
				res.out_slot = '0;
				if (heap_size == 0) begin
					res.status = ST_EMPTY;
				end else begin
					top = heap_slot[1];
					res.out_slot = top;
					res.out_key = slot_key[top];
					swap_entries(1, heap_size);
					heap_pos[top] = '0;
					heap_size--;
					sink(1);
				end
			end
			REQ_INSERT: begin
				if (heap_size >= 64) begin
					res.status = ST_FULL;
				end else if (heap_pos[r.slot] != 0) begin
					res.status = ST_DUP;
				end else begin
					slot_key[r.slot] = r.key;
					heap_size++;
					heap_slot[heap_size] = r.slot;
					heap_pos[r.slot] = heap_size[6:0];
					p = climb(heap_size);
				end
				res.present = heap_pos[r.slot] != 0;
			end
			REQ_CHANGE: begin
				if (heap_pos[r.slot] == 0) begin
					res.status = ST_ABSENT;
				end else begin
					slot_key[r.slot] = r.key;
					p = climb(heap_pos[r.slot]);
					sink(p);
					res.present = 1'b1;
				end
			end
			default: begin
				if (heap_pos[r.slot] == 0) begin
					res.status = ST_ABSENT;
				end else begin
					res.out_key = slot_key[r.slot];
					res.present = 1'b1;
				end
			end
		endcase
		res.occupancy = heap_size[6:0];
		return res;
	endfunction

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 6))) - 3;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic push_req(logic [1:0] t, logic [5:0] s, logic signed [31:0] k);
		req_beat_t r;
		r.req_type = t;
		r.slot = s;
		r.key = k;
		pending_reqs.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_beat_t r;
				r = pending_reqs.pop_front();
				expected_results.push_back(serve_request(r));
				in_valid <= 1'b1;
				req_type <= r.req_type;
				slot <= r.slot;
				key <= r.key;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected beat: status %0d slot %0d key %0d", $time,
						status, out_slot, out_key);
					errors <= errors + 1;
				end else begin
					ipq_res_t e;
					e = expected_results.pop_front();
					if (status !== e.status || out_slot !== e.out_slot ||
						out_key !== e.out_key || present !== e.present ||
						occupancy !== e.occupancy) begin
						$display("%0t mismatch: expected st %0d slot %0d key %0d pres %0d occ %0d",
							$time, e.status, e.out_slot, e.out_key, e.present, e.occupancy);
						$display("%0t            actual st %0d slot %0d key %0d pres %0d occ %0d",
							$time, status, out_slot, out_key, present, occupancy);
						errors <= errors + 1;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("FAIL indexed_max_priority_queue");
			$finish;
		end
	end

	initial begin
		int n;
		int i;
		for (i = 0; i < 64; i++) begin
			heap_pos[i] = '0;
			slot_key[i] = '0;
			heap_slot[i + 1] = '0;
		end
		heap_size = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		push_req(REQ_EXTRACT, 6'd0, 0);
		push_req(REQ_LOOKUP, 6'd63, 0);
		push_req(REQ_CHANGE, 6'd5, 7);
		push_req(REQ_INSERT, 6'd0, 32'sh80000000);
		push_req(REQ_INSERT, 6'd63, 32'sh7fffffff);
		push_req(REQ_INSERT, 6'd7, 5);
		push_req(REQ_INSERT, 6'd8, 5);
		push_req(REQ_INSERT, 6'd9, 5);
		push_req(REQ_INSERT, 6'd7, 1);
		push_req(REQ_LOOKUP, 6'd63, 0);
		push_req(REQ_CHANGE, 6'd0, 32'sh7fffffff);
		push_req(REQ_CHANGE, 6'd63, -1);
		push_req(REQ_EXTRACT, 6'd0, 0);
		push_req(REQ_EXTRACT, 6'd0, 0);
		push_req(REQ_LOOKUP, 6'd0, 0);
		// fill to full, then overflow
		for (i = 0; i < 64; i++)
			push_req(REQ_INSERT, i[5:0], rand_key());
		push_req(REQ_INSERT, 6'd3, 0);
		for (i = 0; i < 70; i++)
			push_req(REQ_EXTRACT, 6'(i), 0);

		for (n = 0; n < 1900; n++) begin
			int w;
			if (n == 640) begin
				wait (pending_reqs.size() == 0);
				send_idle_pct = 73;
				recv_idle_pct = 23;
			end
			if (n == 1280) begin
				wait (pending_reqs.size() == 0);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// random mix of 40% insert, 22% extract, 20% change and 18% lookup
			w = $urandom_range(0, 99);
			if (w < 40)
				push_req(REQ_INSERT, 6'($urandom()), rand_key());
			else if (w < 62)
				push_req(REQ_EXTRACT, 6'($urandom()), rand_key());
			else if (w < 82)
				push_req(REQ_CHANGE, 6'($urandom()), rand_key());
			else
				push_req(REQ_LOOKUP, 6'($urandom()), rand_key());
		end
		wait (pending_reqs.size() == 0);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS indexed_max_priority_queue");
		end else begin
			$display("FAIL indexed_max_priority_queue");
		end
		$finish;
	end
endmodule
